// File: rtl/bwcf_pkg.sv
// Shared types, widths, register indexes and reset values for the box wall
// collision and friction unit. No dependencies.
`timescale 1ns / 1ps

package bwcf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 16;
    localparam int BOX_MIN_WIDTH  = 32;
    localparam int BOX_SIZE_WIDTH = 31;
    localparam int MU_WIDTH       = 17;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 32;
    // Upper face is formed one bit wider than the lower bound so that it never wraps.
    localparam int HI_WIDTH       = BOX_MIN_WIDTH + 1;

    localparam logic [MU_WIDTH-1:0]       MU_ONE        = MU_WIDTH'(65536);
    localparam logic [BOX_MIN_WIDTH-1:0]  BOX_MIN_RST   = '0;
    localparam logic [BOX_SIZE_WIDTH-1:0] BOX_SIZE_RST  = BOX_SIZE_WIDTH'(65536);
    localparam logic [MU_WIDTH-1:0]       MU_RST        = '0;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_MIN_X  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_MIN_Y  = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_MIN_Z  = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_SIZE_X = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_SIZE_Y = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_SIZE_Z = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FRICTION   = 3'd6;

    typedef struct packed {
        logic [2:0][BOX_MIN_WIDTH-1:0]  box_min;
        logic [2:0][BOX_SIZE_WIDTH-1:0] box_size;
        logic [MU_WIDTH-1:0]            mu;
    } box_cfg_t;

    // Width of positions inside the pipeline: wide enough for an input
    // position and for the upper face.
    function automatic int pos_width(input int w);
        return (w > HI_WIDTH) ? w : HI_WIDTH;
    endfunction

endpackage

// File: rtl/bwcf_axis.sv
// One axis of the wall response: clamp, pipelined square root, pipelined
// friction divide and tangential shortening. Depends on bwcf_pkg.
`timescale 1ns / 1ps

module bwcf_axis #(
    parameter int DATA_WIDTH = bwcf_pkg::DATA_WIDTH_DEF,
    parameter int AXIS = 0,
    localparam int PW = bwcf_pkg::pos_width(DATA_WIDTH)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  bwcf_pkg::box_cfg_t                cfg,
    input  logic                              in_valid,
    input  logic [2:0][PW-1:0]                in_p,
    input  logic [2:0][DATA_WIDTH-1:0]        in_v,
    input  logic                              in_stopped,
    output logic                              out_valid,
    output logic [2:0][PW-1:0]                out_p,
    output logic [2:0][DATA_WIDTH-1:0]        out_v,
    output logic                              out_stopped
);
    import bwcf_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int TW  = W + MU_WIDTH;
    localparam int SW  = 2 * W + 1;
    localparam int XW  = SW + 2 * FRAC_BITS;
    localparam int RW  = (XW + 1) / 2;
    localparam int LW  = RW - FRAC_BITS;
    localparam int DRW = LW + 1;
    localparam int QB  = MU_WIDTH;
    localparam int CW  = (TW > RW) ? TW : RW;
    localparam int J0  = (AXIS == 0) ? 1 : 0;
    localparam int J1  = (AXIS == 2) ? 1 : 2;
    localparam int KS  = 2;
    localparam int KC  = KS + RW + 1;
    localparam int KF  = KC + QB + 1;
    localparam int KE  = KF + 1;
    localparam int NS  = KE + 1;

    function automatic logic [W-1:0] mag_f(input logic [W-1:0] x);
        return x[W-1] ? W'(~x + 1'b1) : x;
    endfunction

    logic                     vld_reg  [NS];
    logic                     vld_next [NS];
    logic [2:0][PW-1:0]       p_reg    [NS];
    logic [2:0][PW-1:0]       p_next   [NS];
    logic [2:0][W-1:0]        v_reg    [NS];
    logic [2:0][W-1:0]        v_next   [NS];
    logic                     stp_reg  [NS];
    logic                     stp_next [NS];
    logic                     act_reg  [NS];
    logic                     act_next [NS];
    logic [TW-1:0]            t_reg    [NS];
    logic [TW-1:0]            t_next   [NS];

    logic [W-1:0]             m_reg, m_next;
    logic [2*W-1:0]           sq0_reg, sq0_next, sq1_reg, sq1_next;

    logic [2*RW-1:0]          x_reg     [RW+1];
    logic [2*RW-1:0]          x_next    [RW+1];
    logic [RW+1:0]            rem_reg   [RW+1];
    logic [RW+1:0]            rem_next  [RW+1];
    logic [RW-1:0]            root_reg  [RW+1];
    logic [RW-1:0]            root_next [RW+1];
    logic [RW+3:0]            rem2_w    [RW];
    logic [RW+3:0]            trial_w   [RW];

    logic                     dstop_reg [QB+1];
    logic                     dstop_next[QB+1];
    logic                     ovf_reg   [QB+1];
    logic                     ovf_next  [QB+1];
    logic [LW-1:0]            len_reg   [QB+1];
    logic [LW-1:0]            len_next  [QB+1];
    logic [DRW-1:0]           drem_reg  [QB+1];
    logic [DRW-1:0]           drem_next [QB+1];
    logic [QB-1:0]            q_reg     [QB+1];
    logic [QB-1:0]            q_next    [QB+1];
    logic [DRW-1:0]           dr2_w     [QB];

    logic [W+MU_WIDTH-1:0]    pr0_reg, pr0_next, pr1_reg, pr1_next;
    logic                     fstop_reg, fstop_next;

    logic signed [PW-1:0]     lo_ext, hi_ext, p_in;
    logic                     at_lo, at_hi, v_neg, v_pos;
    logic [RW-1:0]            root_fin;
    logic [LW-1:0]            len_raw, len_c;
    logic                     stop_c;
    logic [MU_WIDTH-1:0]      f_c;
    logic [W-1:0]             a0_f, a1_f, na0, na1;
    logic [SW-1:0]            s_c;

    // Face bounds and classification of the incoming item
    assign lo_ext = PW'($signed(cfg.box_min[AXIS]));
    assign hi_ext = lo_ext + $signed({1'b0, (PW-1)'(cfg.box_size[AXIS])});
    assign p_in   = $signed(in_p[AXIS]);
    assign at_lo  = p_in <= lo_ext;
    assign at_hi  = !at_lo && (p_in >= hi_ext);
    assign v_neg  = in_v[AXIS][W-1];
    assign v_pos  = !v_neg && (in_v[AXIS] != '0);

    assign s_c      = SW'(sq0_reg) + SW'(sq1_reg);
    assign root_fin = root_reg[RW];
    assign len_raw  = root_fin[RW-1:FRAC_BITS];
    assign len_c    = (len_raw == '0) ? LW'(1) : len_raw;
    // Exact static test: s * 2^32 <= t^2, read off the root and remainder of s * 2^32.
    assign stop_c   = (CW'(root_fin) < CW'(t_reg[KC-1]))
                   || ((CW'(root_fin) == CW'(t_reg[KC-1])) && (rem_reg[RW] == '0));
    assign f_c      = ovf_reg[QB] ? MU_ONE : ((q_reg[QB] > MU_ONE) ? MU_ONE : q_reg[QB]);
    assign a0_f     = mag_f(v_reg[KF-1][J0]);
    assign a1_f     = mag_f(v_reg[KF-1][J1]);
    assign na0      = mag_f(v_reg[KF][J0]) - W'(pr0_reg[W+FRAC_BITS-1:FRAC_BITS]);
    assign na1      = mag_f(v_reg[KF][J1]) - W'(pr1_reg[W+FRAC_BITS-1:FRAC_BITS]);

    always_comb
    begin
        // Default: every stage passes its neighbour's item along.
        for (int k = 1; k < NS; k++)
        begin
            vld_next[k] = vld_reg[k-1];
            p_next[k]   = p_reg[k-1];
            v_next[k]   = v_reg[k-1];
            stp_next[k] = stp_reg[k-1];
            act_next[k] = act_reg[k-1];
            t_next[k]   = t_reg[k-1];
        end

        vld_next[0] = in_valid;
        p_next[0]   = in_p;
        v_next[0]   = in_v;
        stp_next[0] = in_stopped;
        act_next[0] = !in_stopped && ((at_lo && v_neg) || (at_hi && v_pos));
        t_next[0]   = '0;
        if (!in_stopped && at_lo)
        begin
            p_next[0][AXIS] = lo_ext;
        end
        else if (!in_stopped && at_hi)
        begin
            p_next[0][AXIS] = hi_ext;
        end
        m_next = mag_f(in_v[AXIS]);

        t_next[1] = TW'(cfg.mu) * TW'(m_reg);
        sq0_next  = (2*W)'(mag_f(v_reg[0][J0])) * (2*W)'(mag_f(v_reg[0][J0]));
        sq1_next  = (2*W)'(mag_f(v_reg[0][J1])) * (2*W)'(mag_f(v_reg[0][J1]));

        x_next[0]    = (2*RW)'(s_c) << (2*FRAC_BITS);
        rem_next[0]  = '0;
        root_next[0] = '0;
        // One root bit per stage
        for (int n = 0; n < RW; n++)
        begin
            rem2_w[n]      = {rem_reg[n], x_reg[n][2*RW-1:2*RW-2]};
            trial_w[n]     = (RW+4)'({root_reg[n], 2'b01});
            x_next[n+1]    = x_reg[n] << 2;
            if (rem2_w[n] >= trial_w[n])
            begin
                rem_next[n+1]  = (RW+2)'(rem2_w[n] - trial_w[n]);
                root_next[n+1] = {root_reg[n][RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[n+1]  = (RW+2)'(rem2_w[n]);
                root_next[n+1] = {root_reg[n][RW-2:0], 1'b0};
            end
        end

        dstop_next[0] = stop_c;
        len_next[0]   = len_c;
        ovf_next[0]   = (W+LW)'(t_reg[KC-1][TW-1:QB]) >= (W+LW)'(len_c);
        drem_next[0]  = DRW'(t_reg[KC-1][TW-1:QB]);
        q_next[0]     = '0;
        // One quotient bit per stage; the top part is below len unless ovf is set (then f is MU_ONE).
        for (int n = 0; n < QB; n++)
        begin
            dr2_w[n]        = {drem_reg[n][LW-1:0], t_reg[KC+n][QB-1-n]};
            dstop_next[n+1] = dstop_reg[n];
            len_next[n+1]   = len_reg[n];
            ovf_next[n+1]   = ovf_reg[n];
            if (dr2_w[n] >= DRW'(len_reg[n]))
            begin
                drem_next[n+1] = dr2_w[n] - DRW'(len_reg[n]);
                q_next[n+1]    = {q_reg[n][QB-2:0], 1'b1};
            end
            else
            begin
                drem_next[n+1] = dr2_w[n];
                q_next[n+1]    = {q_reg[n][QB-2:0], 1'b0};
            end
        end

        fstop_next = dstop_reg[QB];
        pr0_next   = (W+MU_WIDTH)'(a0_f) * (W+MU_WIDTH)'(f_c);
        pr1_next   = (W+MU_WIDTH)'(a1_f) * (W+MU_WIDTH)'(f_c);

        if (act_reg[KF])
        begin
            if (fstop_reg)
            begin
                v_next[KE]   = '0;
                stp_next[KE] = 1'b1;
            end
            else
            begin
                v_next[KE][AXIS] = '0;
                v_next[KE][J0]   = v_reg[KF][J0][W-1] ? W'(~na0 + 1'b1) : na0;
                v_next[KE][J1]   = v_reg[KF][J1][W-1] ? W'(~na1 + 1'b1) : na1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld_reg[k] <= vld_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                p_reg[k]   <= p_next[k];
                v_reg[k]   <= v_next[k];
                stp_reg[k] <= stp_next[k];
                act_reg[k] <= act_next[k];
                t_reg[k]   <= t_next[k];
            end
            for (int n = 0; n <= RW; n++)
            begin
                x_reg[n]    <= x_next[n];
                rem_reg[n]  <= rem_next[n];
                root_reg[n] <= root_next[n];
            end
            for (int n = 0; n <= QB; n++)
            begin
                dstop_reg[n] <= dstop_next[n];
                ovf_reg[n]   <= ovf_next[n];
                len_reg[n]   <= len_next[n];
                drem_reg[n]  <= drem_next[n];
                q_reg[n]     <= q_next[n];
            end
            m_reg     <= m_next;
            sq0_reg   <= sq0_next;
            sq1_reg   <= sq1_next;
            pr0_reg   <= pr0_next;
            pr1_reg   <= pr1_next;
            fstop_reg <= fstop_next;
        end
    end

    assign out_valid   = vld_reg[NS-1];
    assign out_p       = p_reg[NS-1];
    assign out_v       = v_reg[NS-1];
    assign out_stopped = stp_reg[NS-1];

endmodule

// File: rtl/box_wall_collision_friction_unit.sv
// Top level of the box wall collision and friction unit: configuration
// registers, three chained axis pipelines and the output register.
// Depends on bwcf_pkg and bwcf_axis.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | into unit | in_valid / in_ready  | pos_x..z, vel_x..z
//  out     | out       | out_valid/out_ready  | new_pos_x..z, new_vel_x..z
//  cfg     | into unit | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One transfer can be accepted every cycle while the output is not stalled. Each axis
// pipeline holds root stages (one root bit each) and friction divide stages (one
// quotient bit each).
// Reset clears the valid bits and loads the register reset values.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps

module box_wall_collision_friction_unit #(
    parameter int DATA_WIDTH = bwcf_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bwcf_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [bwcf_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [DATA_WIDTH-1:0]         pos_x,
    input  logic signed [DATA_WIDTH-1:0]         pos_y,
    input  logic signed [DATA_WIDTH-1:0]         pos_z,
    input  logic signed [DATA_WIDTH-1:0]         vel_x,
    input  logic signed [DATA_WIDTH-1:0]         vel_y,
    input  logic signed [DATA_WIDTH-1:0]         vel_z,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [DATA_WIDTH-1:0]         new_pos_x,
    output logic signed [DATA_WIDTH-1:0]         new_pos_y,
    output logic signed [DATA_WIDTH-1:0]         new_pos_z,
    output logic signed [DATA_WIDTH-1:0]         new_vel_x,
    output logic signed [DATA_WIDTH-1:0]         new_vel_y,
    output logic signed [DATA_WIDTH-1:0]         new_vel_z
);
    import bwcf_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = pos_width(DATA_WIDTH);

    logic [2:0][BOX_MIN_WIDTH-1:0]  box_min_reg;
    logic [2:0][BOX_SIZE_WIDTH-1:0] box_size_reg;
    logic [MU_WIDTH-1:0]            mu_reg;
    box_cfg_t                       cfg;

    logic                     en;
    logic                     ch_valid [4];
    logic [2:0][PW-1:0]       ch_p     [4];
    logic [2:0][W-1:0]        ch_v     [4];
    logic                     ch_stp   [4];

    logic                     out_valid_reg;
    logic [2:0][W-1:0]        pos_reg, vel_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_reg  <= {3{BOX_MIN_RST}};
            box_size_reg <= {3{BOX_SIZE_RST}};
            mu_reg       <= MU_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BOX_MIN_X:  box_min_reg[0]  <= cfg_data[BOX_MIN_WIDTH-1:0];
                REG_BOX_MIN_Y:  box_min_reg[1]  <= cfg_data[BOX_MIN_WIDTH-1:0];
                REG_BOX_MIN_Z:  box_min_reg[2]  <= cfg_data[BOX_MIN_WIDTH-1:0];
                REG_BOX_SIZE_X: box_size_reg[0] <= cfg_data[BOX_SIZE_WIDTH-1:0];
                REG_BOX_SIZE_Y: box_size_reg[1] <= cfg_data[BOX_SIZE_WIDTH-1:0];
                REG_BOX_SIZE_Z: box_size_reg[2] <= cfg_data[BOX_SIZE_WIDTH-1:0];
                REG_FRICTION:   mu_reg          <= cfg_data[MU_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg.box_min  = box_min_reg;
    assign cfg.box_size = box_size_reg;
    assign cfg.mu       = mu_reg;

    // The whole pipeline moves whenever the output register can take a result.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign ch_valid[0] = in_valid && in_ready;
    assign ch_p[0]     = {PW'(pos_z), PW'(pos_y), PW'(pos_x)};
    assign ch_v[0]     = {vel_z, vel_y, vel_x};
    assign ch_stp[0]   = 1'b0;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        bwcf_axis #(
            .DATA_WIDTH (DATA_WIDTH),
            .AXIS       (a)
        ) u_axis (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (en),
            .cfg         (cfg),
            .in_valid    (ch_valid[a]),
            .in_p        (ch_p[a]),
            .in_v        (ch_v[a]),
            .in_stopped  (ch_stp[a]),
            .out_valid   (ch_valid[a+1]),
            .out_p       (ch_p[a+1]),
            .out_v       (ch_v[a+1]),
            .out_stopped (ch_stp[a+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ch_valid[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= ch_p[3][i][W-1:0];
            end
            vel_reg <= ch_v[3];
        end
    end

    assign out_valid = out_valid_reg;
    assign new_pos_x = pos_reg[0];
    assign new_pos_y = pos_reg[1];
    assign new_pos_z = pos_reg[2];
    assign new_vel_x = vel_reg[0];
    assign new_vel_y = vel_reg[1];
    assign new_vel_z = vel_reg[2];

    // After the x stage the x position always lies on or inside the x faces.
    a_x_inside: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid[1] |->
            ($signed(ch_p[1][0]) >= $signed(PW'($signed(box_min_reg[0]))))
         && ($signed(ch_p[1][0]) <= $signed(PW'($signed(box_min_reg[0])))
                + $signed({1'b0, (PW-1)'(box_size_reg[0])})))
        else $error("x position left the box after the x stage");

    // A particle held by static friction leaves every stage at rest.
    a_stop_y: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid[2] && ch_stp[2] |-> (ch_v[2] == '0))
        else $error("stopped particle still moving after the y stage");

    a_stop_z: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid[3] && ch_stp[3] |-> (ch_v[3] == '0))
        else $error("stopped particle still moving after the z stage");

    // The output register only loads while the pipeline is allowed to move.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vel_reg) && $stable(pos_reg))
        else $error("pending result changed during a stall");

endmodule
